// ----- rtl/core/iqpf_pkg.sv -----
// ----------------------------------------------------------------------------
// iqpf_pkg
// shared constants, types and the arctangent table of the iq-to-polar framer
// ----------------------------------------------------------------------------
`default_nettype none

package iqpf_pkg;

  // frame geometry
  localparam int unsigned SUBCARRIERS = 56;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned POS_W       = $clog2(SUBCARRIERS + 1);

  // cordic geometry
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ITER_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned XY_W         = 27;
  localparam int unsigned Z_W          = 17;
  localparam int unsigned XM_W         = 26;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned PROD_W       = XM_W + GAIN_W;

  localparam logic [GAIN_W-1:0]  CORDIC_GAIN   = 16'd39797;
  localparam logic [15:0]        MAG_MAX       = 16'd46341;
  localparam logic signed [15:0] PHASE_PI      = 16'sd25736;
  localparam logic signed [15:0] PHASE_HALF_PI = 16'sd12868;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              load;
    logic              step;
    logic [ITER_W-1:0] iter;
    logic              finish;
  } iqpf_cmd_t;

  // round(atan(2^-k) * 8192)
  function automatic logic signed [Z_W-1:0] atan_tab(input logic [ITER_W-1:0] k);
    logic signed [Z_W-1:0] v;
    case (k)
      4'd0:    v = 17'sd6434;
      4'd1:    v = 17'sd3798;
      4'd2:    v = 17'sd2007;
      4'd3:    v = 17'sd1019;
      4'd4:    v = 17'sd511;
      4'd5:    v = 17'sd256;
      4'd6:    v = 17'sd128;
      4'd7:    v = 17'sd64;
      4'd8:    v = 17'sd32;
      4'd9:    v = 17'sd16;
      4'd10:   v = 17'sd8;
      4'd11:   v = 17'sd4;
      4'd12:   v = 17'sd2;
      4'd13:   v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/iqpf_cordic.sv -----
// ----------------------------------------------------------------------------
// iqpf_cordic
// vectoring cordic datapath: one rotation per step, then gain scaling
// ----------------------------------------------------------------------------
`default_nettype none

module iqpf_cordic
  import iqpf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire iqpf_cmd_t          cmd_i,
  input  wire logic signed [7:0]  i_value_i,
  input  wire logic signed [7:0]  q_value_i,
  output logic [15:0]             magnitude_o,
  output logic signed [15:0]      phase_angle_o
);

  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]  z_q, z_d;
  logic                   sp_q, sp_d;
  logic [15:0]            sp_mag_q, sp_mag_d;
  logic signed [15:0]     sp_ph_q, sp_ph_d;
  logic [PROD_W-1:0]      prod_q;
  logic signed [15:0]     zc_q;

  logic signed [8:0]      iv, qv, ni, nq;
  logic [8:0]             abs_i, abs_q;
  logic signed [XY_W-1:0] dx, dy;
  logic [XM_W-1:0]        xm;
  logic [PROD_W-1:0]      rnd;
  logic [17:0]            mag_r;
  logic signed [15:0]     z_clamp;

  always_comb begin
    iv    = 9'(i_value_i);
    qv    = 9'(q_value_i);
    ni    = -iv;
    nq    = -qv;
    abs_i = i_value_i[7] ? ni : iv;
    abs_q = q_value_i[7] ? nq : qv;
    dx    = y_q >>> cmd_i.iter;
    dy    = x_q >>> cmd_i.iter;

    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    sp_d     = sp_q;
    sp_mag_d = sp_mag_q;
    sp_ph_d  = sp_ph_q;

    if (cmd_i.load) begin
      sp_d     = (iv == 9'sd0) || (qv == 9'sd0);
      sp_mag_d = 16'd0;
      sp_ph_d  = 16'sd0;
      if (qv == 9'sd0) begin
        sp_mag_d = {abs_i[7:0], 8'd0} | {abs_i[8], 15'd0};
        sp_ph_d  = i_value_i[7] ? PHASE_PI : 16'sd0;
      end else if (iv == 9'sd0) begin
        sp_mag_d = {abs_q[7:0], 8'd0} | {abs_q[8], 15'd0};
        sp_ph_d  = q_value_i[7] ? -PHASE_HALF_PI : PHASE_HALF_PI;
      end
      // pre-rotation into the right half plane
      if (!i_value_i[7]) begin
        x_d = {{(XY_W-25){iv[8]}}, iv, 16'd0};
        y_d = {{(XY_W-25){qv[8]}}, qv, 16'd0};
        z_d = '0;
      end else if (!q_value_i[7]) begin
        x_d = {{(XY_W-25){qv[8]}}, qv, 16'd0};
        y_d = {{(XY_W-25){ni[8]}}, ni, 16'd0};
        z_d = Z_W'(PHASE_HALF_PI);
      end else begin
        x_d = {{(XY_W-25){nq[8]}}, nq, 16'd0};
        y_d = {{(XY_W-25){iv[8]}}, iv, 16'd0};
        z_d = -Z_W'(PHASE_HALF_PI);
      end
    end else if (cmd_i.step) begin
      if (!y_q[XY_W-1]) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_tab(cmd_i.iter);
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_tab(cmd_i.iter);
      end
    end

    xm = x_q[XY_W-1] ? '0 : x_q[XM_W-1:0];

    if (z_q > Z_W'(PHASE_PI)) begin
      z_clamp = PHASE_PI;
    end else if (z_q < -Z_W'(PHASE_PI)) begin
      z_clamp = -PHASE_PI;
    end else begin
      z_clamp = z_q[15:0];
    end

    // round to q8.8 and clamp
    rnd   = prod_q + (PROD_W'(1) << 23);
    mag_r = rnd[PROD_W-1:24];
    if (sp_q) begin
      magnitude_o   = sp_mag_q;
      phase_angle_o = sp_ph_q;
    end else begin
      magnitude_o   = (mag_r > 18'(MAG_MAX)) ? MAG_MAX : mag_r[15:0];
      phase_angle_o = zc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    sp_q     <= sp_d;
    sp_mag_q <= sp_mag_d;
    sp_ph_q  <= sp_ph_d;
    if (cmd_i.finish) begin
      prod_q <= PROD_W'(xm) * PROD_W'(CORDIC_GAIN);
      zc_q   <= z_clamp;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/iqpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// iqpf_ctrl
// sequencer: frame position, frame count, cordic steps and result register
// ----------------------------------------------------------------------------
`default_nettype none

module iqpf_ctrl
  import iqpf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  output iqpf_cmd_t              cmd_o,
  input  wire logic [15:0]       mag_i,
  input  wire logic signed [15:0] phase_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            out_mag_o,
  output logic signed [15:0]     out_phase_o,
  output logic [IDX_W-1:0]       out_idx_o,
  output logic [31:0]            out_frame_o,
  output logic                   out_pad_o,
  output logic                   out_eof_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH,
    ST_EMIT,
    ST_PAD
  } state_e;

  state_e             state_q;
  logic [ITER_W-1:0]  iter_q;
  logic [POS_W-1:0]   pos_q;
  logic [31:0]        frame_q;
  logic               last_q;

  logic               accept, slot_free, room, pos_eof, emit;
  logic [POS_W-1:0]   pos_inc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_o || out_ready_i;
  assign room       = pos_q < POS_W'(SUBCARRIERS);
  assign pos_eof    = pos_q == POS_W'(SUBCARRIERS - 1);
  assign pos_inc    = pos_q + POS_W'(1);
  // result register takes a new item this cycle
  assign emit       = ((state_q == ST_EMIT) || (state_q == ST_PAD)) && slot_free;

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.step   = (state_q == ST_CALC);
    cmd_o.iter   = iter_q;
    cmd_o.finish = (state_q == ST_FINISH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      pos_q       <= '0;
      frame_q     <= '0;
      last_q      <= 1'b0;
      out_valid_o <= 1'b0;
      out_mag_o   <= '0;
      out_phase_o <= '0;
      out_idx_o   <= '0;
      out_frame_o <= '0;
      out_pad_o   <= 1'b0;
      out_eof_o   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q <= in_last_i;
            iter_q <= '0;
            if (room) begin
              state_q <= ST_CALC;
            end else if (in_last_i) begin
              // frame already full: close it with no further items
              pos_q   <= '0;
              frame_q <= frame_q + 32'd1;
            end
          end
        end
        ST_CALC: begin
          iter_q <= iter_q + ITER_W'(1);
          if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_mag_o   <= mag_i;
            out_phase_o <= phase_i;
            out_idx_o   <= pos_q[IDX_W-1:0];
            out_frame_o <= frame_q;
            out_pad_o   <= 1'b0;
            out_eof_o   <= pos_eof;
            if (!last_q) begin
              pos_q   <= pos_inc;
              state_q <= ST_IDLE;
            end else if (pos_eof) begin
              pos_q   <= '0;
              frame_q <= frame_q + 32'd1;
              state_q <= ST_IDLE;
            end else begin
              pos_q   <= pos_inc;
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (slot_free) begin
            out_mag_o   <= '0;
            out_phase_o <= '0;
            out_idx_o   <= pos_q[IDX_W-1:0];
            out_frame_o <= frame_q;
            out_pad_o   <= 1'b1;
            out_eof_o   <= pos_eof;
            if (pos_eof) begin
              pos_q   <= '0;
              frame_q <= frame_q + 32'd1;
              state_q <= ST_IDLE;
            end else begin
              pos_q <= pos_inc;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/iq_to_polar_subcarrier_framer.sv -----
// ----------------------------------------------------------------------------
// iq_to_polar_subcarrier_framer
// converts i/q subcarrier pairs to magnitude and phase and frames them
// a pair is loaded on acceptance, rotated by the 16-step cordic loop in
// ST_CALC, gain-scaled in ST_FINISH and registered in ST_EMIT; no new pair
// is taken before that; padding items follow at one a cycle unless stalled
// reset: asynchronous, clears position, frame count and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module iq_to_polar_subcarrier_framer
  import iqpf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input pairs
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // i_value [7:0], q_value [15:8]
  input  wire logic        s_axis_tlast,  // last pair of the buffer
  // polar results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // magnitude [15:0], phase_angle [31:16],
                                          // subcarrier_index [37:32],
                                          // frame_number [69:38], zero [71:70]
  output logic [0:0]       m_axis_tuser,  // is_padding [0]
  output logic             m_axis_tlast   // end of frame
);

  iqpf_cmd_t          cmd;
  logic [15:0]        dp_mag;
  logic signed [15:0] dp_phase;
  logic [15:0]        out_mag;
  logic signed [15:0] out_phase;
  logic [IDX_W-1:0]   out_idx;
  logic [31:0]        out_frame;
  logic               out_pad;

  // sequencer owns frame position, frame count and the result register
  iqpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd),
    .mag_i       (dp_mag),
    .phase_i     (dp_phase),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_mag_o   (out_mag),
    .out_phase_o (out_phase),
    .out_idx_o   (out_idx),
    .out_frame_o (out_frame),
    .out_pad_o   (out_pad),
    .out_eof_o   (m_axis_tlast)
  );

  // cordic datapath samples the pair on the load command
  iqpf_cordic u_cordic (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .i_value_i     (s_axis_tdata[7:0]),
    .q_value_i     (s_axis_tdata[15:8]),
    .magnitude_o   (dp_mag),
    .phase_angle_o (dp_phase)
  );

  // pack the result fields, lowest field first
  assign m_axis_tdata = {2'b00, out_frame, out_idx, out_phase, out_mag};
  assign m_axis_tuser = out_pad;

endmodule

`default_nettype wire
